// ----- hw/rtl/avm_pkg.sv -----
// Shared types and constants for the accelerometer vector magnitude block.
package avm_pkg;

    localparam int AXIS_W    = 12;
    localparam int MAG_W     = 12;
    localparam int READY_BIT = 3;
    localparam logic [MAG_W-1:0] MAG_MAX = 12'hFFF;
    localparam int AXIS_MAX  = 2047;
    localparam int AXIS_MIN  = -2048;

    typedef struct packed {
        logic [7:0] status_byte;
        logic [7:0] x_high;
        logic [7:0] x_low;
        logic [7:0] y_high;
        logic [7:0] y_low;
        logic [7:0] z_high;
        logic [7:0] z_low;
    } avm_in_t;

    typedef struct packed {
        logic signed [AXIS_W-1:0] x_accel;
        logic signed [AXIS_W-1:0] y_accel;
        logic signed [AXIS_W-1:0] z_accel;
        logic        [MAG_W-1:0]  magnitude;
    } avm_out_t;

    // Side data carried along the square root pipeline.
    typedef struct packed {
        logic signed [AXIS_W-1:0] x_accel;
        logic signed [AXIS_W-1:0] y_accel;
        logic signed [AXIS_W-1:0] z_accel;
        logic                     data_ready;
    } avm_tag_t;

endpackage

// ----- hw/rtl/avm_axis_lane.sv -----
// One axis lane: unpack, saturate for output, and square the magnitude.
module avm_axis_lane #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                              aclk,
    input  logic                              en,
    input  logic [7:0]                        hi_byte,
    input  logic [7:0]                        lo_byte,
    output logic signed [avm_pkg::AXIS_W-1:0] axis_out,
    output logic [2*SAMPLE_BITS-1:0]          square_out
);
    import avm_pkg::*;

    localparam int CW = (SAMPLE_BITS > AXIS_W) ? SAMPLE_BITS : AXIS_W;
    localparam logic signed [CW-1:0] CLAMP_HI = CW'(AXIS_MAX);
    localparam logic signed [CW-1:0] CLAMP_LO = CW'(AXIS_MIN);

    logic [15:0]                 word;
    logic signed [SAMPLE_BITS-1:0] raw;
    logic signed [CW-1:0]        raw_ext;
    logic signed [AXIS_W-1:0]    axis_next;
    logic [SAMPLE_BITS-1:0]      abs_val;
    logic signed [AXIS_W-1:0]    axis_reg;
    logic [2*SAMPLE_BITS-1:0]    square_reg;

    assign word    = {hi_byte, lo_byte};
    // Left-justified sample: keep the top bits, drop the unused low ones.
    assign raw     = $signed(word[15 -: SAMPLE_BITS]);
    assign raw_ext = CW'(raw);

    always_comb begin
        if (raw_ext > CLAMP_HI) begin
            axis_next = AXIS_W'(CLAMP_HI);
        end else if (raw_ext < CLAMP_LO) begin
            axis_next = AXIS_W'(CLAMP_LO);
        end else begin
            axis_next = raw_ext[AXIS_W-1:0];
        end
    end

    // The most negative value wraps to its own pattern, which reads right unsigned.
    assign abs_val = raw[SAMPLE_BITS-1] ? (~raw + 1'b1) : raw;

    always_ff @(posedge aclk) begin
        if (en) begin
            axis_reg   <= axis_next;
            square_reg <= abs_val * abs_val;
        end
    end

    assign axis_out   = axis_reg;
    assign square_out = square_reg;

endmodule

// ----- hw/rtl/avm_isqrt.sv -----
// Pipelined floor square root, one root bit per stage, with side data.
module avm_isqrt #(
    parameter int ROOT_W = 13
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [2*ROOT_W-1:0]     radicand,
    input  avm_pkg::avm_tag_t       in_tag,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [ROOT_W-1:0]       root,
    output avm_pkg::avm_tag_t       out_tag
);
    import avm_pkg::*;

    logic [ROOT_W-1:0]   valid_reg;
    logic [ROOT_W:0]     adv;
    logic [ROOT_W+1:0]   rem_reg [ROOT_W];
    logic [ROOT_W-1:0]   q_reg   [ROOT_W];
    logic [2*ROOT_W-1:0] rad_reg [ROOT_W];
    avm_tag_t            tag_reg [ROOT_W];

    // A stage may load when it is empty or its content moves on.
    assign adv[ROOT_W] = out_ready;
    for (genvar k = ROOT_W - 1; k >= 0; k--) begin : g_adv
        assign adv[k] = !valid_reg[k] || adv[k+1];
    end

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic                 v_in;
        logic [ROOT_W+1:0]    rem_in;
        logic [ROOT_W-1:0]    q_in;
        logic [2*ROOT_W-1:0]  rad_in;
        avm_tag_t             tag_in;
        logic [ROOT_W+1:0]    rem_sh;
        logic [ROOT_W+1:0]    trial;
        logic                 take;

        if (k == 0) begin : g_first
            assign v_in   = in_valid;
            assign rem_in = '0;
            assign q_in   = '0;
            assign rad_in = radicand;
            assign tag_in = in_tag;
        end else begin : g_mid
            assign v_in   = valid_reg[k-1];
            assign rem_in = rem_reg[k-1];
            assign q_in   = q_reg[k-1];
            assign rad_in = rad_reg[k-1];
            assign tag_in = tag_reg[k-1];
        end

        // Bring down the next two radicand bits and try root bit one.
        assign rem_sh = {rem_in[ROOT_W-1:0], rad_in[2*ROOT_W-1 -: 2]};
        assign trial  = {q_in, 2'b01};
        assign take   = (rem_sh >= trial);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (adv[k]) begin
                valid_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv[k]) begin
                rem_reg[k] <= take ? (rem_sh - trial) : rem_sh;
                q_reg[k]   <= {q_in[ROOT_W-2:0], take};
                rad_reg[k] <= {rad_in[2*ROOT_W-3:0], 2'b00};
                tag_reg[k] <= tag_in;
            end
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = valid_reg[ROOT_W-1];
    assign root      = q_reg[ROOT_W-1];
    assign out_tag   = tag_reg[ROOT_W-1];

endmodule

// ----- hw/rtl/accel_vector_magnitude.sv -----
// Top level of the accelerometer vector magnitude block.
// Each beat carries one sample: a status byte and a high/low byte pair per axis holding a
// left-justified SAMPLE_BITS-bit two's complement value. Three axis lanes unpack, saturate
// to 12 bits and square their values into registers; the squares are summed and fed to a
// square root pipeline that settles one root bit per stage (SAMPLE_BITS + 1 stages); an
// output register holds the result. One sample is taken every cycle while the output is
// not stalled. Magnitude is the floor square root saturated at 4095, or zero when status
// bit 3 is clear.
module accel_vector_magnitude #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  avm_pkg::avm_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output avm_pkg::avm_out_t m_data
);
    import avm_pkg::*;

    localparam int ROOT_W = SAMPLE_BITS + 1;
    localparam int SUM_W  = 2 * ROOT_W;
    localparam int EXT_W  = (ROOT_W > MAG_W) ? ROOT_W : MAG_W;

    logic                      lane_en;
    logic                      lane_valid_reg;
    logic                      ready_flag_reg;
    logic signed [AXIS_W-1:0]  x_axis, y_axis, z_axis;
    logic [2*SAMPLE_BITS-1:0]  x_sq, y_sq, z_sq;
    logic [SUM_W-1:0]          sum_sq;
    avm_tag_t                  lane_tag;
    logic                      sq_in_ready;
    logic                      sq_out_valid;
    logic [ROOT_W-1:0]         sq_root;
    avm_tag_t                  sq_tag;
    logic [EXT_W-1:0]          root_ext;
    logic                      out_load;
    logic                      m_valid_reg;
    avm_out_t                  m_data_reg;
    avm_out_t                  m_data_next;

    assign lane_en = !lane_valid_reg || sq_in_ready;
    assign s_ready = lane_en;

    avm_axis_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_x (
        .aclk(aclk), .en(lane_en), .hi_byte(s_data.x_high), .lo_byte(s_data.x_low),
        .axis_out(x_axis), .square_out(x_sq)
    );
    avm_axis_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_y (
        .aclk(aclk), .en(lane_en), .hi_byte(s_data.y_high), .lo_byte(s_data.y_low),
        .axis_out(y_axis), .square_out(y_sq)
    );
    avm_axis_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_z (
        .aclk(aclk), .en(lane_en), .hi_byte(s_data.z_high), .lo_byte(s_data.z_low),
        .axis_out(z_axis), .square_out(z_sq)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lane_valid_reg <= 1'b0;
        end else if (lane_en) begin
            lane_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (lane_en) begin
            ready_flag_reg <= s_data.status_byte[READY_BIT];
        end
    end

    // Merge the lanes: one three-input add feeds the root pipeline.
    assign sum_sq = SUM_W'(x_sq) + SUM_W'(y_sq) + SUM_W'(z_sq);

    always_comb begin
        lane_tag.x_accel    = x_axis;
        lane_tag.y_accel    = y_axis;
        lane_tag.z_accel    = z_axis;
        lane_tag.data_ready = ready_flag_reg;
    end

    avm_isqrt #(.ROOT_W(ROOT_W)) u_isqrt (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(lane_valid_reg), .in_ready(sq_in_ready),
        .radicand(sum_sq), .in_tag(lane_tag),
        .out_valid(sq_out_valid), .out_ready(out_load),
        .root(sq_root), .out_tag(sq_tag)
    );

    assign out_load = !m_valid_reg || m_ready;
    assign root_ext = EXT_W'(sq_root);

    always_comb begin
        m_data_next.x_accel = sq_tag.x_accel;
        m_data_next.y_accel = sq_tag.y_accel;
        m_data_next.z_accel = sq_tag.z_accel;
        if (!sq_tag.data_ready) begin
            m_data_next.magnitude = '0;
        end else if (root_ext > EXT_W'(MAG_MAX)) begin
            m_data_next.magnitude = MAG_MAX;
        end else begin
            m_data_next.magnitude = root_ext[MAG_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= sq_out_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_lane_empty_accepts: assert property (@(posedge aclk) disable iff (!aresetn)
        !lane_valid_reg |-> s_ready)
        else $error("empty lane stage refused a beat");

    a_result_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (sq_out_valid && out_load) |=> m_valid)
        else $error("finished root did not reach the output register");

    a_not_ready_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (sq_out_valid && out_load && !sq_tag.data_ready) |=> (m_data.magnitude == '0))
        else $error("magnitude not zero for a sample without data ready");

endmodule

// ----- dv/tb_accel_vector_magnitude.sv -----
// Self-checking testbench for the accelerometer vector magnitude block.
module tb_accel_vector_magnitude;
    import avm_pkg::*;

    localparam int SAMPLE_BITS = 12;
    localparam int RAND_ITEMS  = 1350;
    localparam int MAX_REPORTS = 10;
    localparam int DRAIN_LIMIT = 20000;
    localparam int TAIL_CYCLES = SAMPLE_BITS + 8;

    typedef struct {
        avm_in_t  sample;
        bit       known;
        avm_out_t want;
    } stim_row_t;

    logic     aclk     = 1'b0;
    logic     aresetn  = 1'b0;
    logic     s_valid  = 1'b0;
    logic     s_ready;
    avm_in_t  s_data   = '0;
    logic     m_valid;
    logic     m_ready  = 1'b0;
    avm_out_t m_data;

    avm_out_t pend_result = '0;
    avm_out_t result_q[$];
    int       mismatches  = 0;

    int       rx_mode     = 0;
    int       rx_left     = 0;
    int       rx_phase    = 0;

    accel_vector_magnitude #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

    // Unpack a left-justified two's complement sample from its byte pair.
    function automatic int unpack_axis(logic [7:0] hi, logic [7:0] lo);
        logic [15:0] word;
        int          raw;
        word = {hi, lo};
        raw  = int'(word >> (16 - SAMPLE_BITS));
        if (raw >= (1 << (SAMPLE_BITS - 1)))
            raw -= (1 << SAMPLE_BITS);
        return raw;
    endfunction

    function automatic logic signed [AXIS_W-1:0] clip_axis(int v);
        int c;
        c = v;
        if (c > AXIS_MAX) c = AXIS_MAX;
        if (c < AXIS_MIN) c = AXIS_MIN;
        return AXIS_W'(c);
    endfunction

    // Floor square root, settling one result bit at a time from the top.
    function automatic int unsigned floor_root(int unsigned v);
        int unsigned r;
        int unsigned t;
        r = 0;
        for (int b = 15; b >= 0; b--) begin
            t = r | (32'd1 << b);
            if (t * t <= v)
                r = t;
        end
        return r;
    endfunction

    function automatic avm_out_t predict_sample(avm_in_t smp);
        avm_out_t    res;
        int          x;
        int          y;
        int          z;
        int unsigned root;
        x = unpack_axis(smp.x_high, smp.x_low);
        y = unpack_axis(smp.y_high, smp.y_low);
        z = unpack_axis(smp.z_high, smp.z_low);
        root = 0;
        if (smp.status_byte[READY_BIT]) begin
            root = floor_root(int'(x * x) + int'(y * y) + int'(z * z));
            if (root > MAG_MAX)
                root = MAG_MAX;
        end
        res.x_accel   = clip_axis(x);
        res.y_accel   = clip_axis(y);
        res.z_accel   = clip_axis(z);
        res.magnitude = MAG_W'(root);
        return res;
    endfunction

    function automatic avm_in_t mk_in(logic [7:0] st, logic [7:0] xh, logic [7:0] xl,
                                      logic [7:0] yh, logic [7:0] yl,
                                      logic [7:0] zh, logic [7:0] zl);
        avm_in_t smp;
        smp.status_byte = st;
        smp.x_high = xh;
        smp.x_low  = xl;
        smp.y_high = yh;
        smp.y_low  = yl;
        smp.z_high = zh;
        smp.z_low  = zl;
        return smp;
    endfunction

    function automatic avm_out_t mk_out(int x, int y, int z, int mag);
        avm_out_t res;
        res.x_accel   = AXIS_W'(x);
        res.y_accel   = AXIS_W'(y);
        res.z_accel   = AXIS_W'(z);
        res.magnitude = MAG_W'(mag);
        return res;
    endfunction

    // Byte pair for one axis: mostly random, with weight on extremes and near zero.
    function automatic logic [15:0] random_axis();
        logic [7:0] lo;
        lo = 8'($urandom);
        case ($urandom_range(0, 9))
            0:       return {8'h80, 4'h0, lo[3:0]};
            1:       return {8'h7F, 4'hF, lo[3:0]};
            2:       return {8'h00, lo};
            3:       return {8'hFF, lo};
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic avm_in_t random_sample();
        avm_in_t     smp;
        logic [15:0] xa;
        logic [15:0] ya;
        logic [15:0] za;
        xa = random_axis();
        ya = random_axis();
        za = random_axis();
        smp = mk_in(8'($urandom), xa[15:8], xa[7:0], ya[15:8], ya[7:0], za[15:8], za[7:0]);
        smp.status_byte[READY_BIT] = ($urandom_range(0, 3) != 0);
        return smp;
    endfunction

    // Present one beat and hold it until accepted.
    task automatic send_sample(input avm_in_t smp, input avm_out_t want);
        s_data      <= smp;
        pend_result <= want;
        s_valid     <= 1'b1;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    task automatic wait_results_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (result_q.size() != 0)
            @(posedge aclk);
    endtask

    // Receiver: switch at random between stall patterns, holding each for a random run.
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode <= $urandom_range(0, 3);
            rx_left <= $urandom_range(16, 300);
        end else begin
            rx_left <= rx_left - 1;
        end
        rx_phase <= (rx_phase + 1) % 4;
        case (rx_mode)
            0:       m_ready <= 1'b1;
            1:       m_ready <= ($urandom_range(0, 1) == 1);
            2:       m_ready <= (rx_phase == 0);
            default: m_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Queue the expected result of each accepted beat, check each delivered one.
    always @(posedge aclk) begin
        avm_out_t want;
        if (aresetn) begin
            if (s_valid && s_ready)
                result_q.push_back(pend_result);
            if (m_valid && m_ready) begin
                if (result_q.size() == 0) begin
                    if (mismatches < MAX_REPORTS)
                        $display("unexpected result beat: x=%0d y=%0d z=%0d mag=%0d",
                                 m_data.x_accel, m_data.y_accel, m_data.z_accel,
                                 m_data.magnitude);
                    mismatches++;
                end else begin
                    want = result_q.pop_front();
                    if (m_data.x_accel !== want.x_accel || m_data.y_accel !== want.y_accel ||
                        m_data.z_accel !== want.z_accel ||
                        m_data.magnitude !== want.magnitude) begin
                        if (mismatches < MAX_REPORTS)
                            $display({"result mismatch: expected x=%0d y=%0d z=%0d mag=%0d,",
                                      " got x=%0d y=%0d z=%0d mag=%0d"},
                                     want.x_accel, want.y_accel, want.z_accel, want.magnitude,
                                     m_data.x_accel, m_data.y_accel, m_data.z_accel,
                                     m_data.magnitude);
                        mismatches++;
                    end
                end
            end
        end
    end

    initial begin
        stim_row_t rows[$];
        avm_in_t   smp;
        int        burst_left;
        int        gap;
        int        waited;

        // Rows with a typed result, then rows left to the predictor.
        rows.push_back('{mk_in(8'h08, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 1'b1,
                         mk_out(0, 0, 0, 0)});
        rows.push_back('{mk_in(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 1'b1,
                         mk_out(0, 0, 0, 0)});
        rows.push_back('{mk_in(8'h08, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 1'b1,
                         mk_out(-2048, 0, 0, 2048)});
        rows.push_back('{mk_in(8'h08, 8'h7F, 8'hF0, 8'h00, 8'h00, 8'h00, 8'h00), 1'b1,
                         mk_out(2047, 0, 0, 2047)});
        rows.push_back('{mk_in(8'h08, 8'h00, 8'h00, 8'h80, 8'h00, 8'h00, 8'h00), 1'b1,
                         mk_out(0, -2048, 0, 2048)});
        rows.push_back('{mk_in(8'h08, 8'h00, 8'h00, 8'h00, 8'h00, 8'h7F, 8'hF0), 1'b1,
                         mk_out(0, 0, 2047, 2047)});
        rows.push_back('{mk_in(8'h08, 8'h80, 8'h00, 8'h80, 8'h00, 8'h80, 8'h00), 1'b1,
                         mk_out(-2048, -2048, -2048, 3547)});
        rows.push_back('{mk_in(8'h08, 8'h7F, 8'hF0, 8'h7F, 8'hF0, 8'h7F, 8'hF0), 1'b1,
                         mk_out(2047, 2047, 2047, 3545)});
        // Data not ready with other status bits set: axes pass, magnitude zero.
        rows.push_back('{mk_in(8'hF7, 8'h80, 8'h00, 8'h80, 8'h00, 8'h80, 8'h00), 1'b1,
                         mk_out(-2048, -2048, -2048, 0)});
        rows.push_back('{mk_in(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF), 1'b1,
                         mk_out(-1, -1, -1, 1)});
        // Unused low bits of the low byte are dropped.
        rows.push_back('{mk_in(8'h08, 8'h00, 8'h0F, 8'h00, 8'h0F, 8'h00, 8'h0F), 1'b1,
                         mk_out(0, 0, 0, 0)});
        rows.push_back('{mk_in(8'h08, 8'h00, 8'h10, 8'h00, 8'h00, 8'h00, 8'h00), 1'b1,
                         mk_out(1, 0, 0, 1)});
        rows.push_back('{mk_in(8'h08, 8'h00, 8'h30, 8'h00, 8'h40, 8'h00, 8'h00), 1'b1,
                         mk_out(3, 4, 0, 5)});
        rows.push_back('{mk_in(8'h00, 8'h00, 8'h30, 8'h00, 8'h40, 8'h00, 8'h00), 1'b1,
                         mk_out(3, 4, 0, 0)});
        rows.push_back('{mk_in(8'h08, 8'h80, 8'h10, 8'h7F, 8'hFF, 8'hFF, 8'hF0), 1'b1,
                         mk_out(-2047, 2047, -1, 2894)});
        rows.push_back('{mk_in(8'hAA, 8'h55, 8'hA5, 8'hAA, 8'h5A, 8'h12, 8'h34), 1'b0, '0});
        rows.push_back('{mk_in(8'h55, 8'hAA, 8'h5A, 8'h55, 8'hA5, 8'hED, 8'hCB), 1'b0, '0});
        rows.push_back('{mk_in(8'h0C, 8'h3F, 8'hC0, 8'hC0, 8'h3F, 8'h01, 8'hFE), 1'b0, '0});
        rows.push_back('{mk_in(8'h08, 8'h0B, 8'h50, 8'hF4, 8'hB0, 8'h40, 8'h00), 1'b0, '0});
        rows.push_back('{mk_in(8'h18, 8'hC3, 8'h9E, 8'h26, 8'h71, 8'hDA, 8'h87), 1'b0, '0});

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i]) begin
            if ($urandom_range(0, 2) == 0) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
            send_sample(rows[i].sample,
                        rows[i].known ? rows[i].want : predict_sample(rows[i].sample));
        end
        wait_results_drained();

        burst_left = 0;
        for (int i = 0; i < RAND_ITEMS; i++) begin
            if (i == RAND_ITEMS / 2)
                wait_results_drained();
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 40);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap != 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            smp = random_sample();
            send_sample(smp, predict_sample(smp));
            burst_left--;
        end
        s_valid <= 1'b0;

        waited = 0;
        while (result_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (mismatches == 0 && result_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
